[hdl/sbe_pkg.sv]
// Shared types, constants and S-box functions for the 64-bit SIT block cipher.
package sbe_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned NUM_KEYS = 5;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_FIVE  = 3'd4;

    typedef logic [WORD_W-1:0] word_t;

    // Four 16-bit words of a block; w1 sits in the low bits.
    typedef struct packed {
        word_t w4;
        word_t w3;
        word_t w2;
        word_t w1;
    } blk_t;

    localparam word_t KEY_RESET [NUM_KEYS] = '{
        16'h0123, 16'h4567, 16'h89ab, 16'hcdef, 16'h0123
    };

    localparam logic [3:0] SBOX_P [16] = '{
        4'd3, 4'd15, 4'd14, 4'd0, 4'd5, 4'd4, 4'd11, 4'd12,
        4'd13, 4'd10, 4'd9, 4'd6, 4'd7, 4'd8, 4'd2, 4'd1
    };

    localparam logic [3:0] SBOX_Q [16] = '{
        4'd9, 4'd14, 4'd5, 4'd6, 4'd10, 4'd2, 4'd3, 4'd12,
        4'd15, 4'd0, 4'd4, 4'd13, 4'd7, 4'd11, 4'd1, 4'd8
    };

    function automatic logic [3:0] lut_p(input logic [3:0] x);
        return SBOX_P[x];
    endfunction

    function automatic logic [3:0] lut_q(input logic [3:0] x);
        return SBOX_Q[x];
    endfunction

    // F function: three S-box layers with half-nibble mixing between layers
    function automatic word_t mix_f(input word_t x);
        logic [3:0] p10, q10, p20, q20;
        logic [3:0] q11, p11, q21, p21;
        logic [3:0] p12, q12, p22, q22;
        p10 = lut_p(x[15:12]);
        q10 = lut_q(x[11:8]);
        p20 = lut_p(x[7:4]);
        q20 = lut_q(x[3:0]);

        q11 = lut_q({p10[3:2], q10[3:2]});
        p11 = lut_p({p10[1:0], p20[3:2]});
        q21 = lut_q({q10[1:0], q20[3:2]});
        p21 = lut_p({p20[1:0], q20[1:0]});

        p12 = lut_p({q11[3:2], p11[3:2]});
        q12 = lut_q({q11[1:0], q21[3:2]});
        p22 = lut_p({p11[1:0], p21[3:2]});
        q22 = lut_q({q21[1:0], p21[1:0]});
        return {p12, q12, p22, q22};
    endfunction

endpackage

[hdl/sit_block_encrypt_64_unit.sv]
// Top level of the 64-bit SIT block cipher: key registers and a chain of round cells.
// A block is registered in each round cell in turn; the last cell's register drives the ciphertext.
// Throughput: one block per cycle while the output is not stalled; each round cell holds one block in flight.
// A stalled output holds the last cell and every full cell behind it; empty cells keep filling bubbles.
// Reset (rst_n, async, active low): empties every cell and loads the default keys.
// Each cell reads its key live; write keys only while the chain is empty.
module sit_block_encrypt_64_unit #(
    parameter int ROUNDS = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [63:0]                     plaintext,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [63:0]                     ciphertext,
    input  logic                            cfg_wr_en,
    input  logic [sbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbe_pkg::WORD_W-1:0]      cfg_wdata
);
    import sbe_pkg::*;

    // Round keys: five registers, reset to the default schedule
    word_t key_reg [NUM_KEYS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_reg[i] <= KEY_RESET[i];
            end
        end
        else if (cfg_wr_en)
        begin
            // Drop writes to indexes beyond the key list
            unique case (cfg_index)
                REG_ROUND_KEY_ONE:   key_reg[0] <= cfg_wdata;
                REG_ROUND_KEY_TWO:   key_reg[1] <= cfg_wdata;
                REG_ROUND_KEY_THREE: key_reg[2] <= cfg_wdata;
                REG_ROUND_KEY_FOUR:  key_reg[3] <= cfg_wdata;
                REG_ROUND_KEY_FIVE:  key_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Chain links: index 0 is the input side, index ROUNDS the output side
    logic link_valid [ROUNDS+1];
    logic link_ready [ROUNDS+1];
    blk_t link_blk   [ROUNDS+1];

    assign link_valid[0] = in_valid;
    assign in_ready      = link_ready[0];
    assign link_blk[0]   = blk_t'(plaintext);

    genvar g;
    generate
        for (g = 0; g < ROUNDS; g++)
        begin : g_round
            blk_t cell_in;

            // A cell stores {d, c, b, a}; the next round sees w1=b, w2=a, w3=d, w4=c.
            // The first cell reads the plaintext words as they stand.
            if (g == 0)
            begin : g_first
                assign cell_in = link_blk[0];
            end
            else
            begin : g_next
                assign cell_in = '{w4: link_blk[g].w3, w3: link_blk[g].w4,
                                   w2: link_blk[g].w1, w1: link_blk[g].w2};
            end

            sbe_round_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .key       (key_reg[g]),
                .in_valid  (link_valid[g]),
                .in_ready  (link_ready[g]),
                .in_blk    (cell_in),
                .out_valid (link_valid[g+1]),
                .out_ready (link_ready[g+1]),
                .out_blk   (link_blk[g+1])
            );
        end
    endgenerate

    // The last cell's register is the output register; its layout is the ciphertext
    assign link_ready[ROUNDS] = out_ready;
    assign out_valid          = link_valid[ROUNDS];
    assign ciphertext         = link_blk[ROUNDS];

endmodule

[hdl/sbe_round_cell.sv]
// One Feistel round cell: combinational round followed by a holding register.
module sbe_round_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  sbe_pkg::word_t key,
    input  logic          in_valid,
    output logic          in_ready,
    input  sbe_pkg::blk_t in_blk,
    output logic          out_valid,
    input  logic          out_ready,
    output sbe_pkg::blk_t out_blk
);
    import sbe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    blk_t  data_reg;
    blk_t  data_next;
    word_t a, b, c, d;

    // Take a new block when empty or when the held one moves on
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        a = ~(in_blk.w1 ^ key);
        d = ~(in_blk.w4 ^ key);
        b = mix_f(a) ^ in_blk.w3;
        c = mix_f(d) ^ in_blk.w2;
        data_next = '{w4: d, w3: c, w2: b, w1: a};
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = data_reg;

endmodule

[hdl/sbe_checker.sv]
// Port-level checker for the 64-bit SIT block cipher, bound to the top level.
module sbe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [63:0]                   plaintext,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [63:0]                   ciphertext
);

    // Hold an offered block steady until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(plaintext))
        else $error("plaintext offer dropped or changed before transfer");

    // Hold a result until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(ciphertext))
        else $error("ciphertext changed while stalled");

    // A free output side leaves the whole chain ready
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with no result waiting");

endmodule

bind sit_block_encrypt_64_unit sbe_checker u_sbe_checker (.*);
